/* rtl/bqc_pkg.sv */
// Shared types, symbol and character constants for the bracket, quote and comment checker.
// No dependencies; used by bqc_cell, bqc_ctrl and bracket_quote_comment_checker.
`timescale 1ns / 1ps

package bqc_pkg;

  // Default number of cells in the symbol stack.
  localparam int unsigned StackDepthDefault = 64;

  // Character codes that the checker looks at.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Pending symbol held in one stack cell.
  typedef enum logic [2:0] {
    SYM_PAREN  = 3'd0,
    SYM_BRACK  = 3'd1,
    SYM_BRACE  = 3'd2,
    SYM_SQUOTE = 3'd3,
    SYM_DQUOTE = 3'd4,
    SYM_SLASH  = 3'd5,
    SYM_STAR   = 3'd6,
    SYM_NONE   = 3'd7
  } sym_e;

  // Error kind reported with each result.
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_QUOTE    = 2'd1,
    KIND_CLOSE    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  // Movement of the whole cell chain in one cycle.
  typedef enum logic [2:0] {
    SH_HOLD = 3'd0,
    SH_PUSH = 3'd1,
    SH_POP1 = 3'd2,
    SH_POP2 = 3'd3,
    SH_POP3 = 3'd4
  } shift_e;

  // Symbol code pushed for a character.
  function automatic sym_e sym_of(input logic [7:0] c);
    sym_e s;
    case (c)
      CH_LPAREN: s = SYM_PAREN;
      CH_LBRACK: s = SYM_BRACK;
      CH_LBRACE: s = SYM_BRACE;
      CH_SQUOTE: s = SYM_SQUOTE;
      CH_DQUOTE: s = SYM_DQUOTE;
      CH_SLASH:  s = SYM_SLASH;
      CH_STAR:   s = SYM_STAR;
      default:   s = SYM_NONE;
    endcase
    return s;
  endfunction

endpackage

/* rtl/bqc_cell.sv */
// One cell of the symbol stack chain: holds a symbol and takes its neighbor's on a shift.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_cell (
  input  logic           clk_i,
  input  bqc_pkg::shift_e op_i,
  input  bqc_pkg::sym_e   above_i,
  input  bqc_pkg::sym_e   below1_i,
  input  bqc_pkg::sym_e   below2_i,
  input  bqc_pkg::sym_e   below3_i,
  output bqc_pkg::sym_e   sym_o
);

  bqc_pkg::sym_e sym_q, sym_d;

  // Pick the new content from the neighbor that the shift brings here.
  always_comb begin
    case (op_i)
      bqc_pkg::SH_PUSH: sym_d = above_i;
      bqc_pkg::SH_POP1: sym_d = below1_i;
      bqc_pkg::SH_POP2: sym_d = below2_i;
      bqc_pkg::SH_POP3: sym_d = below3_i;
      default:          sym_d = sym_q;
    endcase
  end

  // Stack contents are data only; the depth counter says which cells are live.
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign sym_o = sym_q;

endmodule

/* rtl/bqc_ctrl.sv */
// Control step of the checker: comment flags, depth, line and error counters,
// chain shift command and the result register. Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_ctrl #(
  parameter int unsigned STACK_DEPTH = bqc_pkg::StackDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_in_i,
  input  logic            end_of_text_i,
  input  bqc_pkg::sym_e   cell0_i,
  input  bqc_pkg::sym_e   cell1_i,
  input  bqc_pkg::sym_e   cell2_i,
  output bqc_pkg::shift_e op_o,
  output bqc_pkg::sym_e   push_sym_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      error_kind_o,
  output logic [31:0]     error_line_o,
  output logic [7:0]      offending_char_o,
  output logic [6:0]      unclosed_count_o,
  output logic [15:0]     error_total_o,
  output logic            done_res_o
);

  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW1 = DW + 1;
  localparam int unsigned SW  = ((DW > 16) ? DW : 16) + 1;

  // State registers.
  logic [DW-1:0] depth_q, depth_d;
  logic          lc_q, lc_d;
  logic          bc_q, bc_d;
  logic [31:0]   line_q, line_d;
  logic [15:0]   err_q, err_d;

  // Result register.
  logic          ovalid_q, ovalid_d;
  bqc_pkg::kind_e r_kind_q, r_kind_d;
  logic [31:0]   r_line_q, r_line_d;
  logic [7:0]    r_char_q, r_char_d;
  logic [6:0]    r_uncl_q, r_uncl_d;
  logic [15:0]   r_total_q, r_total_d;
  logic          r_done_q, r_done_d;

  logic accept;
  logic is_nl, is_star, is_slash, is_open, is_close, is_quote;
  logic nz, full, top_quote, closes_top;
  bqc_pkg::sym_e top;
  logic push, pop, push_ok, push_fail, pair, post_gt1;
  bqc_pkg::sym_e post0, post1;
  bqc_pkg::kind_e kind, kind_f;
  logic lc_n, bc_n;
  logic [31:0] line_n, eline;
  logic [15:0] err_n;
  logic [SW-1:0] total;
  logic [DW1-1:0] depth_sum;

  // The result register frees up whenever its request is taken.
  assign in_ready_o = !ovalid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Character classes and stack top.
  always_comb begin
    is_nl    = (char_in_i == bqc_pkg::CH_NL);
    is_star  = (char_in_i == bqc_pkg::CH_STAR);
    is_slash = (char_in_i == bqc_pkg::CH_SLASH);
    is_open  = (char_in_i == bqc_pkg::CH_LPAREN) || (char_in_i == bqc_pkg::CH_LBRACK) ||
               (char_in_i == bqc_pkg::CH_LBRACE);
    is_close = (char_in_i == bqc_pkg::CH_RPAREN) || (char_in_i == bqc_pkg::CH_RBRACK) ||
               (char_in_i == bqc_pkg::CH_RBRACE);
    is_quote = (char_in_i == bqc_pkg::CH_SQUOTE) || (char_in_i == bqc_pkg::CH_DQUOTE);
    nz       = (depth_q != '0);
    full     = (depth_q == DW'(STACK_DEPTH));
    top      = nz ? cell0_i : bqc_pkg::SYM_NONE;
    top_quote = (top == bqc_pkg::SYM_SQUOTE) || (top == bqc_pkg::SYM_DQUOTE);
    closes_top = ((top == bqc_pkg::SYM_PAREN) && (char_in_i == bqc_pkg::CH_RPAREN)) ||
                 ((top == bqc_pkg::SYM_BRACK) && (char_in_i == bqc_pkg::CH_RBRACK)) ||
                 ((top == bqc_pkg::SYM_BRACE) && (char_in_i == bqc_pkg::CH_RBRACE));
  end

  // Examine the character: decide push, pop, flag changes and early errors.
  always_comb begin
    push = 1'b0;
    pop  = 1'b0;
    kind = bqc_pkg::KIND_NONE;
    lc_n = lc_q;
    bc_n = bc_q;
    if (lc_q || bc_q) begin
      if (lc_q && is_nl) begin
        lc_n = 1'b0;
      end else if (bc_q) begin
        if (nz && (top == bqc_pkg::SYM_STAR)) begin
          if (is_slash) begin
            bc_n = 1'b0;
          end
          pop = 1'b1;
        end else if (is_star) begin
          push = 1'b1;
        end
      end
    end else if (nz) begin
      if (is_nl && top_quote) begin
        pop  = 1'b1;
        kind = bqc_pkg::KIND_QUOTE;
      end else if (top_quote) begin
        if (((top == bqc_pkg::SYM_SQUOTE) && (char_in_i == bqc_pkg::CH_SQUOTE)) ||
            ((top == bqc_pkg::SYM_DQUOTE) && (char_in_i == bqc_pkg::CH_DQUOTE))) begin
          pop = 1'b1;
        end
      end else if (is_open || is_quote) begin
        push = 1'b1;
      end else if (closes_top) begin
        pop = 1'b1;
      end else if (is_close) begin
        kind = bqc_pkg::KIND_CLOSE;
      end else if (top == bqc_pkg::SYM_SLASH) begin
        if (is_star) begin
          bc_n = 1'b1;
        end else if (is_slash) begin
          lc_n = 1'b1;
        end
        pop = 1'b1;
      end else if (is_slash) begin
        push = 1'b1;
      end
    end else begin
      if (is_close) begin
        kind = bqc_pkg::KIND_CLOSE;
      end else if (is_open || is_quote || is_slash) begin
        push = 1'b1;
      end
    end
  end

  // Comment opener test on the top two entries after the examine step.
  always_comb begin
    push_ok   = push && !full;
    push_fail = push && full;
    if (push_ok) begin
      post0    = bqc_pkg::sym_of(char_in_i);
      post1    = cell0_i;
      post_gt1 = nz;
    end else if (pop) begin
      post0    = cell1_i;
      post1    = cell2_i;
      post_gt1 = (depth_q >= DW'(3));
    end else begin
      post0    = cell0_i;
      post1    = cell1_i;
      post_gt1 = (depth_q >= DW'(2));
    end
    pair = (kind == bqc_pkg::KIND_NONE) && post_gt1 && (post1 == bqc_pkg::SYM_SLASH) &&
           ((post0 == bqc_pkg::SYM_SLASH) || (post0 == bqc_pkg::SYM_STAR));
  end

  // Chain command for this cycle.
  always_comb begin
    op_o = bqc_pkg::SH_HOLD;
    if (accept && !end_of_text_i) begin
      if (push_ok && pair) begin
        op_o = bqc_pkg::SH_POP1;
      end else if (push_ok) begin
        op_o = bqc_pkg::SH_PUSH;
      end else if (pop && pair) begin
        op_o = bqc_pkg::SH_POP3;
      end else if (pop) begin
        op_o = bqc_pkg::SH_POP1;
      end else if (pair) begin
        op_o = bqc_pkg::SH_POP2;
      end
    end
  end

  assign push_sym_o = bqc_pkg::sym_of(char_in_i);

  // Counters, final error kind and end-of-text totals.
  always_comb begin
    line_n = (is_nl && (line_q != 32'hFFFF_FFFF)) ? line_q + 32'd1 : line_q;
    kind_f = kind;
    if ((kind == bqc_pkg::KIND_NONE) && push_fail) begin
      kind_f = bqc_pkg::KIND_OVERFLOW;
    end
    case (kind_f)
      bqc_pkg::KIND_QUOTE:    eline = (line_n != 32'd0) ? line_n - 32'd1 : 32'd0;
      bqc_pkg::KIND_CLOSE:    eline = line_n;
      bqc_pkg::KIND_OVERFLOW: eline = line_n;
      default:                eline = 32'd0;
    endcase
    err_n = ((kind_f != bqc_pkg::KIND_NONE) && (err_q != 16'hFFFF)) ? err_q + 16'd1 : err_q;
    depth_sum = DW1'(depth_q) + DW1'(push_ok) - DW1'(pop) - (pair ? DW1'(2) : DW1'(0));
    total = SW'(err_q) + SW'(depth_q);
  end

  // Next state and result on an accepted request.
  always_comb begin
    depth_d   = depth_q;
    lc_d      = lc_q;
    bc_d      = bc_q;
    line_d    = line_q;
    err_d     = err_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    r_kind_d  = r_kind_q;
    r_line_d  = r_line_q;
    r_char_d  = r_char_q;
    r_uncl_d  = r_uncl_q;
    r_total_d = r_total_q;
    r_done_d  = r_done_q;
    if (accept) begin
      ovalid_d = 1'b1;
      if (end_of_text_i) begin
        depth_d   = '0;
        lc_d      = 1'b0;
        bc_d      = 1'b0;
        line_d    = 32'd1;
        err_d     = 16'd0;
        r_kind_d  = bqc_pkg::KIND_NONE;
        r_line_d  = 32'd0;
        r_char_d  = 8'd0;
        r_uncl_d  = 7'(depth_q);
        r_total_d = (total > SW'(16'hFFFF)) ? 16'hFFFF : total[15:0];
        r_done_d  = 1'b1;
      end else begin
        depth_d   = DW'(depth_sum);
        // A comment opener left on top of the stack sets its flag.
        lc_d      = lc_n || (pair && (post0 == bqc_pkg::SYM_SLASH));
        bc_d      = bc_n || (pair && (post0 == bqc_pkg::SYM_STAR));
        line_d    = line_n;
        err_d     = err_n;
        r_kind_d  = kind_f;
        r_line_d  = eline;
        r_char_d  = (kind_f != bqc_pkg::KIND_NONE) ? char_in_i : 8'd0;
        r_uncl_d  = 7'd0;
        r_total_d = err_n;
        r_done_d  = 1'b0;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      lc_q     <= 1'b0;
      bc_q     <= 1'b0;
      line_q   <= 32'd1;
      err_q    <= 16'd0;
      ovalid_q <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      lc_q     <= lc_d;
      bc_q     <= bc_d;
      line_q   <= line_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    r_kind_q  <= r_kind_d;
    r_line_q  <= r_line_d;
    r_char_q  <= r_char_d;
    r_uncl_q  <= r_uncl_d;
    r_total_q <= r_total_d;
    r_done_q  <= r_done_d;
  end

  assign out_valid_o      = ovalid_q;
  assign error_kind_o     = r_kind_q;
  assign error_line_o     = r_line_q;
  assign offending_char_o = r_char_q;
  assign unclosed_count_o = r_uncl_q;
  assign error_total_o    = r_total_q;
  assign done_res_o       = r_done_q;

endmodule

/* rtl/bracket_quote_comment_checker.sv */
// Top level of the bracket, quote and comment checker: a chain of stack cells
// and the control step. Depends on bqc_pkg, bqc_cell and bqc_ctrl.
`timescale 1ns / 1ps

// The checker takes one source character per request and returns one result per
// request, in the cycle after acceptance, through an output register; with the
// output side ready it accepts a request every cycle. The symbol stack is a chain
// of STACK_DEPTH cells that shifts by up to one place down or three places up each
// cycle, so every character costs a single step of the control logic regardless of
// stack depth. An end-of-text request reports the unclosed count and error total
// and returns the checker to its reset state. No clearing pass follows reset.
module bracket_quote_comment_checker #(
  parameter int unsigned STACK_DEPTH = bqc_pkg::StackDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  error_kind_o,
  output logic [31:0] error_line_o,
  output logic [7:0]  offending_char_o,
  output logic [6:0]  unclosed_count_o,
  output logic [15:0] error_total_o,
  output logic        done_res_o
);

  bqc_pkg::shift_e op;
  bqc_pkg::sym_e   push_sym;
  bqc_pkg::sym_e   ext [STACK_DEPTH + 3];

  // Cell outputs, padded below the chain with empty symbols.
  genvar g;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      bqc_cell u_cell (
        .clk_i    (clk_i),
        .op_i     (op),
        .above_i  ((g == 0) ? push_sym : ext[(g == 0) ? 0 : g - 1]),
        .below1_i (ext[g + 1]),
        .below2_i (ext[g + 2]),
        .below3_i (ext[g + 3]),
        .sym_o    (ext[g])
      );
    end
    for (g = STACK_DEPTH; g < STACK_DEPTH + 3; g++) begin : g_pad
      assign ext[g] = bqc_pkg::SYM_NONE;
    end
  endgenerate

  // Control step.
  bqc_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .end_of_text_i    (end_of_text_i),
    .cell0_i          (ext[0]),
    .cell1_i          (ext[1]),
    .cell2_i          (ext[2]),
    .op_o             (op),
    .push_sym_o       (push_sym),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .error_kind_o     (error_kind_o),
    .error_line_o     (error_line_o),
    .offending_char_o (offending_char_o),
    .unclosed_count_o (unclosed_count_o),
    .error_total_o    (error_total_o),
    .done_res_o       (done_res_o)
  );

endmodule
